// ===== hdl/wdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, command queue and output
// stage.
// ----------------------------------------------------------------------------
package wdf_pkg;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_MASK    = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  // Frame type codes as seen on the output
  localparam logic [2:0] FT_UNKNOWN = 3'd0;
  localparam logic [2:0] FT_TEXT    = 3'd1;
  localparam logic [2:0] FT_BINARY  = 3'd2;
  localparam logic [2:0] FT_PING    = 3'd3;
  localparam logic [2:0] FT_PONG    = 3'd4;

  // Opcodes of the first header byte
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header byte counts at which the next decision is taken
  localparam logic [3:0] NEED_BASE  = 4'd2;
  localparam logic [3:0] NEED_EXT16 = 4'd4;
  localparam logic [3:0] NEED_EXT64 = 4'd10;
  localparam logic [3:0] MASK_BYTES = 4'd4;

  // One result word handed from the parser to the output stage
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] mask;
    logic       has_data;
    logic [2:0] frame_type;
    logic       frame_end;
  } cmd_t;

  // Map an opcode byte to its frame type
  function automatic logic [2:0] classify(input logic [7:0] op);
    logic [2:0] ft;
    unique case (op[3:0])
      OP_TEXT:   ft = FT_TEXT;
      OP_BINARY: ft = FT_BINARY;
      OP_PING:   ft = FT_PING;
      OP_PONG:   ft = FT_PONG;
      default:   ft = FT_UNKNOWN;
    endcase
    return ft;
  endfunction

endpackage

// ===== hdl/wdf_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Takes one byte a cycle unless the queue is full, walks the frame header and
// turns each payload byte (or an empty frame's end marker) into a queue entry.
// ----------------------------------------------------------------------------
module wdf_front
  import wdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       q_ready_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  need_q, need_d;
  logic [2:0]  kind_q, kind_d;
  logic        masked_q, masked_d;
  logic [31:0] key_q, key_d;
  logic [63:0] len_q, len_d;
  logic [1:0]  idx_q, idx_d;

  logic        accept;
  logic [3:0]  cnt_inc;
  logic [63:0] len_shift;
  logic [6:0]  len7;
  logic [7:0]  key_byte;
  logic        go_header;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign cnt_inc    = cnt_q + 4'd1;
  assign len_shift  = {len_q[55:0], in_byte_i};
  assign len7       = in_byte_i[6:0];

  // Pick the key byte for the current payload position
  always_comb begin
    unique case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Advance the parser on each accepted byte
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    need_d    = need_q;
    kind_d    = kind_q;
    masked_d  = masked_q;
    key_d     = key_q;
    len_d     = len_q;
    idx_d     = idx_q;
    push_o    = 1'b0;
    go_header = 1'b0;
    cmd_o     = '{data: 8'd0, mask: 8'd0, has_data: 1'b0,
                  frame_type: kind_q, frame_end: 1'b1};
    if (accept) begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          push_o         = 1'b1;
          cmd_o.data     = in_byte_i;
          cmd_o.mask     = masked_q ? key_byte : 8'd0;
          cmd_o.has_data = 1'b1;
          cmd_o.frame_end = (len_q == 64'd1);
          len_d          = len_q - 64'd1;
          idx_d          = idx_q + 2'd1;
          go_header      = (len_q == 64'd1);
        end
        PH_HEADER: begin
          cnt_d = cnt_inc;
          if (cnt_q == 4'd0) begin
            kind_d = classify(in_byte_i);
          end else begin
            masked_d = in_byte_i[7];
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
              phase_d = PH_LENGTH;
              need_d  = (len7 == LEN_EXT16) ? NEED_EXT16 : NEED_EXT64;
              len_d   = 64'd0;
            end else if (in_byte_i[7]) begin
              len_d   = {57'd0, len7};
              phase_d = PH_MASK;
              need_d  = cnt_inc + MASK_BYTES;
              key_d   = 32'd0;
            end else begin
              len_d   = {57'd0, len7};
              phase_d = PH_PAYLOAD;
              idx_d   = 2'd0;
              if (len7 == 7'd0) begin
                push_o    = 1'b1;
                go_header = 1'b1;
              end
            end
          end
        end
        PH_LENGTH: begin
          cnt_d = cnt_inc;
          len_d = len_shift;
          if (cnt_inc >= need_q) begin
            if (masked_q) begin
              phase_d = PH_MASK;
              need_d  = cnt_inc + MASK_BYTES;
              key_d   = 32'd0;
            end else begin
              phase_d = PH_PAYLOAD;
              idx_d   = 2'd0;
              if (len_shift == 64'd0) begin
                push_o    = 1'b1;
                go_header = 1'b1;
              end
            end
          end
        end
        PH_MASK: begin
          cnt_d = cnt_inc;
          key_d = {key_q[23:0], in_byte_i};
          if (cnt_inc >= need_q) begin
            phase_d = PH_PAYLOAD;
            idx_d   = 2'd0;
            if (len_q == 64'd0) begin
              push_o    = 1'b1;
              go_header = 1'b1;
            end
          end
        end
        default: begin
          go_header = 1'b1;
        end
      endcase
      // Drop back to header parsing once the frame is done
      if (go_header) begin
        phase_d  = PH_HEADER;
        cnt_d    = 4'd0;
        need_d   = NEED_BASE;
        kind_d   = FT_UNKNOWN;
        masked_d = 1'b0;
        len_d    = 64'd0;
        idx_d    = 2'd0;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= 4'd0;
      need_q   <= NEED_BASE;
      kind_q   <= FT_UNKNOWN;
      masked_q <= 1'b0;
      key_q    <= 32'd0;
      len_q    <= 64'd0;
      idx_q    <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      need_q   <= need_d;
      kind_q   <= kind_d;
      masked_q <= masked_d;
      key_q    <= key_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
    end
  end

`ifndef SYNTHESIS
  // A command only ever comes from an accepted word
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept)
    else $error("command pushed without an accepted word");

  // An empty-frame marker always closes its frame
  a_marker_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !cmd_o.has_data) |-> cmd_o.frame_end)
    else $error("data-less command not marked as frame end");

  // The length register stays clear while the header is read
  a_header_len_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (len_q == 64'd0))
    else $error("length not clear in header phase");
`endif

endmodule

// ===== hdl/wdf_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Small FIFO between the parser and the output stage so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module wdf_queue
  import wdf_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o   = (cnt_q != FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = store_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/wdf_back.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Pops commands, applies the mask byte and holds the result word in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module wdf_back
  import wdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_has_data_o,
  output logic [2:0] out_type_o,
  output logic       out_end_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       has_q;
  logic [2:0] type_q;
  logic       end_q;

  // Load when the output register is free or being drained
  assign pop_o = q_valid_i & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Unmask and capture the word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_cmd_i.data ^ q_cmd_i.mask;
      has_q  <= q_cmd_i.has_data;
      type_q <= q_cmd_i.frame_type;
      end_q  <= q_cmd_i.frame_end;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_data_o     = data_q;
  assign out_has_data_o = has_q;
  assign out_type_o     = type_q;
  assign out_end_o      = end_q;

endmodule

// ===== hdl/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser: bytes in, unmasked payload words out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per word in tdata[7:0]. Header, extended
//   length and mask key bytes are consumed without output.
//   m_axis carries one word per payload byte: tdata is the unmasked byte,
//   tuser[0] flags real data (clear on the single marker word of an empty
//   frame, whose tdata is zero), tuser[3:1] is the frame type (0 unknown,
//   1 text, 2 binary, 3 ping, 4 pong) and tlast marks the frame's last word.
//   A payload byte accepted on s_axis is written into the command queue, then
//   loaded into the output register, from which it is shown on m_axis.
//   Throughput: one byte per cycle while the queue is not full; header bytes
//   are taken at that same rate.
//   Reset puts the parser in header phase and empties the command queue; no
//   clearing pass is needed. When the receiver stalls, the output register
//   holds its word, the queue fills (QueueDepth words) and then s_axis_tready
//   drops until space frees up again.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
  import wdf_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] data_byte
  output logic [3:0] m_axis_tuser,  // [0] has_data, [3:1] frame_type
  output logic       m_axis_tlast
);

  logic push;
  cmd_t push_cmd;
  logic q_ready;
  logic pop;
  logic q_valid;
  cmd_t pop_cmd;

  // Parse incoming bytes
  wdf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouple parser from output
  wdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  // Unmask and present results
  wdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (pop_cmd),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_has_data_o (m_axis_tuser[0]),
    .out_type_o     (m_axis_tuser[3:1]),
    .out_end_o      (m_axis_tlast)
  );

endmodule
